>>> src/reassembly_ring_buffer_macros.svh
// Assertion helpers for the reassembly ring buffer.
// Each expects clock and reset in scope.
`ifndef REASSEMBLY_RING_BUFFER_MACROS_SVH
`define REASSEMBLY_RING_BUFFER_MACROS_SVH

// Same-cycle implication.
`define RRB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RRB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types and fixed field widths of the reassembly ring buffer.
// ----------------------------------------------------------------------------
package rrb_pkg;

   localparam int MODE_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int FIELD_W = 13;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND  = 3'd0,
      MODE_POP     = 3'd1,
      MODE_PEEK    = 3'd2,
      MODE_DISCARD = 3'd3,
      MODE_SEGMENT = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MERGE,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } merge_status_type;

endpackage

>>> src/rrb_ram.sv
// ----------------------------------------------------------------------------
// rrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rrb_merge_engine.sv
// ----------------------------------------------------------------------------
// rrb_merge_engine
// Pending block table and the walker that merges a finished segment span
// into it, one table entry per cycle.
// ----------------------------------------------------------------------------
`include "reassembly_ring_buffer_macros.svh"

module rrb_merge_engine #(
   parameter int RING_BYTES = 4096,
   parameter int MAX_BLOCKS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [$clog2(RING_BYTES)-1:0]      tail,
   input  logic [$clog2(RING_BYTES)-1:0]      left,
   input  logic [$clog2(RING_BYTES+1)-1:0]    cnt,
   input  logic [$clog2(RING_BYTES+1)-1:0]    fill,
   output rrb_pkg::merge_status_type          status,
   output logic [$clog2(RING_BYTES+1)-1:0]    moved
);

   import rrb_pkg::*;

   localparam int AW  = $clog2(RING_BYTES);
   localparam int CW  = $clog2(RING_BYTES + 1);
   localparam int RW  = $clog2(2 * RING_BYTES);
   localparam int IW  = $clog2(MAX_BLOCKS + 1);
   localparam int IXW = $clog2(MAX_BLOCKS);

   logic [AW-1:0]         bstart_ff [MAX_BLOCKS];
   logic [AW-1:0]         bstart_in [MAX_BLOCKS];
   logic [CW-1:0]         blen_ff   [MAX_BLOCKS];
   logic [CW-1:0]         blen_in   [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] bvalid_ff, bvalid_in;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          tmode_ff, tmode_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] left_ff, left_in;
   logic [AW-1:0] sstart_ff, sstart_in;
   logic [RW-1:0] right_ff, right_in;
   logic [IW-1:0] i_ff, i_in;
   logic [CW-1:0] moved_ff, moved_in;

   logic [IXW-1:0] idx;
   logic           cur_valid;
   logic [AW-1:0]  cur_start;
   logic [CW-1:0]  cur_len;
   logic [RW-1:0]  pb, e_end, span, start_sum;
   logic [CW-1:0]  room, new_len;
   logic           hit, do_drop, do_wr;
   logic [IXW-1:0] drop_idx, wr_idx;

   assign idx       = i_ff[IXW-1:0];
   assign cur_valid = (i_ff < IW'(MAX_BLOCKS)) && bvalid_ff[idx];
   assign cur_start = bstart_ff[idx];
   assign cur_len   = blen_ff[idx];

   // distance of the block start past the tail, modulo the ring
   assign pb = (cur_start >= tail_ff) ? RW'(cur_start) - RW'(tail_ff)
                                      : RW'(cur_start) + RW'(RING_BYTES) - RW'(tail_ff);
   assign e_end = pb + RW'(cur_len);
   assign hit   = tmode_ff ? (pb <= right_ff)
                           : ((RW'(left_ff) <= e_end) && (pb <= right_ff));

   assign start_sum = RW'(tail) + RW'(left);
   assign room      = CW'(RING_BYTES) - fill;
   assign span      = right_ff - RW'(left_ff);
   assign new_len   = (span > RW'(RING_BYTES)) ? CW'(RING_BYTES) : span[CW-1:0];

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      tmode_in  = tmode_ff;
      tail_in   = tail_ff;
      left_in   = left_ff;
      sstart_in = sstart_ff;
      right_in  = right_ff;
      i_in      = i_ff;
      moved_in  = moved_ff;
      do_drop   = 1'b0;
      drop_idx  = idx;
      do_wr     = 1'b0;
      wr_idx    = idx;

      if (start) begin
         busy_in   = 1'b1;
         tmode_in  = (left == '0);
         tail_in   = tail;
         left_in   = left;
         sstart_in = (start_sum >= RW'(RING_BYTES)) ?
                     AW'(start_sum - RW'(RING_BYTES)) : start_sum[AW-1:0];
         right_in  = RW'(left) + RW'(cnt);
         i_in      = '0;
      end else if (busy_ff) begin
         if (cur_valid) begin
            if (hit) begin
               // absorb the block and close the gap it leaves
               do_drop = 1'b1;
               if (e_end > right_ff) begin
                  right_in = e_end;
               end
               if (!tmode_ff && (pb < RW'(left_ff))) begin
                  left_in   = pb[AW-1:0];
                  sstart_in = cur_start;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (tmode_ff) begin
               moved_in = (right_ff > RW'(room)) ? room : right_ff[CW-1:0];
            end else begin
               moved_in = '0;
               do_wr    = 1'b1;
               if (i_ff >= IW'(MAX_BLOCKS)) begin
                  // table full: evict the oldest block
                  do_drop  = 1'b1;
                  drop_idx = '0;
                  wr_idx   = IXW'(MAX_BLOCKS - 1);
               end
            end
         end
      end

      bstart_in = bstart_ff;
      blen_in   = blen_ff;
      bvalid_in = bvalid_ff;
      for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
         if (do_drop && (k >= int'(drop_idx))) begin
            bstart_in[k] = bstart_ff[k+1];
            blen_in[k]   = blen_ff[k+1];
            bvalid_in[k] = bvalid_ff[k+1];
         end
      end
      if (do_drop) begin
         bstart_in[MAX_BLOCKS-1] = '0;
         blen_in[MAX_BLOCKS-1]   = '0;
         bvalid_in[MAX_BLOCKS-1] = 1'b0;
      end
      if (do_wr) begin
         bstart_in[wr_idx] = sstart_ff;
         blen_in[wr_idx]   = new_len;
         bvalid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         bvalid_ff <= '0;
         for (int k = 0; k < MAX_BLOCKS; k++) begin
            bstart_ff[k] <= '0;
            blen_ff[k]   <= '0;
         end
      end else begin
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         bvalid_ff <= bvalid_in;
         bstart_ff <= bstart_in;
         blen_ff   <= blen_in;
      end
   end

   always_ff @(posedge clock) begin
      tmode_ff  <= tmode_in;
      tail_ff   <= tail_in;
      left_ff   <= left_in;
      sstart_ff <= sstart_in;
      right_ff  <= right_in;
      i_ff      <= i_in;
      moved_ff  <= moved_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign moved       = moved_ff;

   `RRB_ASSERT_NOW(a_blocks_packed, 1'b1,
      ((bvalid_ff + 1'b1) & bvalid_ff) == '0, "block table not packed")
   `RRB_ASSERT_NEXT(a_done_ends_walk, done_ff, !busy_ff || start,
      "merge walker busy after done")
   `RRB_ASSERT_NOW(a_start_when_free, start, !busy_ff, "merge started while busy")

endmodule

>>> src/reassembly_ring_buffer.sv
// Byte operations: the sequencer holds each transaction through execute and finish,
// registers the result on leaving finish, and accepts no new item until then.
// Segment end with merge: the merge state waits on the merge walker, one block table
// entry per cycle.
// Reset clears pointers, counters and the block table at once; ring contents
// stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// reassembly_ring_buffer
// Byte ring buffer with out-of-order segment reassembly over a ring RAM.
// ----------------------------------------------------------------------------
`include "reassembly_ring_buffer_macros.svh"

module reassembly_ring_buffer #(
   parameter int RING_BYTES = 4096,
   parameter int MAX_BLOCKS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rrb_pkg::MODE_W-1:0]   req_mode,
   input  logic [rrb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [rrb_pkg::FIELD_W-1:0]  req_byte_offset,
   input  logic [rrb_pkg::FIELD_W-1:0]  req_drop_count,
   input  logic                         req_segment_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rrb_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_out_valid,
   output logic [rrb_pkg::FIELD_W-1:0]  rsp_moved_count,
   output logic [rrb_pkg::FIELD_W-1:0]  rsp_fill_level
);

   import rrb_pkg::*;

   localparam int AW = $clog2(RING_BYTES);
   localparam int CW = $clog2(RING_BYTES + 1);
   localparam int XW = ((CW > FIELD_W) ? CW : FIELD_W) + 2;

   function automatic logic [AW-1:0] wrap(input logic [XW-1:0] x);
      logic [XW-1:0] y;
      y = (x >= XW'(RING_BYTES)) ? x - XW'(RING_BYTES) : x;
      return y[AW-1:0];
   endfunction

   seq_state_type state_ff, state_in;

   logic [MODE_W-1:0]  mode_ff;
   logic [BYTE_W-1:0]  data_ff;
   logic [FIELD_W-1:0] off_ff, drop_ff;
   logic               last_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] segidx_ff, segidx_in;
   logic [CW-1:0] segsto_ff, segsto_in;

   logic          pend_rd_ff, pend_rd_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [CW-1:0] pend_moved_ff, pend_moved_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [FIELD_W-1:0] rsp_moved_ff, rsp_moved_in;
   logic [FIELD_W-1:0] rsp_fill_ff, rsp_fill_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [BYTE_W-1:0] rd_data;

   logic             merge_start;
   merge_status_type merge_stat;
   logic [CW-1:0]    merge_moved;

   logic [XW-1:0] reach, drop_n, moved_x, fill_x;
   logic [AW-1:0] tail;
   logic [CW-1:0] stored_n;

   assign tail   = wrap(XW'(head_ff) + XW'(fill_ff));
   assign reach  = XW'(fill_ff) + XW'(off_ff) + XW'(segidx_ff);
   assign drop_n = (XW'(drop_ff) < XW'(fill_ff)) ? XW'(drop_ff) : XW'(fill_ff);
   assign stored_n = (reach < XW'(RING_BYTES)) ? segsto_ff + 1'b1 : segsto_ff;
   assign moved_x  = XW'(pend_moved_ff);
   assign fill_x   = XW'(fill_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      segidx_in     = segidx_ff;
      segsto_in     = segsto_ff;
      pend_rd_in    = pend_rd_ff;
      pend_valid_in = pend_valid_ff;
      pend_moved_in = pend_moved_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_moved_in  = rsp_moved_ff;
      rsp_fill_in   = rsp_fill_ff;
      wr_en         = 1'b0;
      wr_addr       = tail;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      merge_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            pend_rd_in    = 1'b0;
            pend_valid_in = 1'b0;
            pend_moved_in = '0;
            state_in      = ST_FINISH;
            case (mode_ff)
               MODE_APPEND: begin
                  if (fill_ff < CW'(RING_BYTES)) begin
                     wr_en         = 1'b1;
                     fill_in       = fill_ff + 1'b1;
                     pend_valid_in = 1'b1;
                  end
               end
               MODE_POP: begin
                  if (fill_ff != '0) begin
                     rd_en         = 1'b1;
                     head_in       = wrap(XW'(head_ff) + XW'(1));
                     fill_in       = fill_ff - 1'b1;
                     pend_rd_in    = 1'b1;
                     pend_valid_in = 1'b1;
                  end
               end
               MODE_PEEK: begin
                  if (XW'(off_ff) < XW'(fill_ff)) begin
                     rd_en         = 1'b1;
                     rd_addr       = wrap(XW'(head_ff) + XW'(off_ff));
                     pend_rd_in    = 1'b1;
                     pend_valid_in = 1'b1;
                  end
               end
               MODE_DISCARD: begin
                  head_in       = wrap(XW'(head_ff) + drop_n);
                  fill_in       = fill_ff - drop_n[CW-1:0];
                  pend_moved_in = drop_n[CW-1:0];
                  pend_valid_in = (drop_n != '0);
               end
               MODE_SEGMENT: begin
                  if (reach < XW'(RING_BYTES)) begin
                     wr_en         = 1'b1;
                     wr_addr       = wrap(XW'(head_ff) + reach);
                     pend_valid_in = 1'b1;
                  end
                  segsto_in = stored_n;
                  if (segidx_ff < CW'(RING_BYTES)) begin
                     segidx_in = segidx_ff + 1'b1;
                  end
                  if (last_ff) begin
                     segidx_in = '0;
                     segsto_in = '0;
                     if ((stored_n != '0) && (XW'(off_ff) < XW'(RING_BYTES))) begin
                        merge_start = 1'b1;
                        state_in    = ST_MERGE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_MERGE: begin
            if (merge_stat.done) begin
               fill_in       = fill_ff + merge_moved;
               pend_moved_in = merge_moved;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_rd_ff ? rd_data : '0;
               rsp_ok_in    = pend_valid_ff;
               rsp_moved_in = moved_x[FIELD_W-1:0];
               rsp_fill_in  = fill_x[FIELD_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         segidx_ff    <= '0;
         segsto_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         segidx_ff    <= segidx_in;
         segsto_ff    <= segsto_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         mode_ff <= req_mode;
         data_ff <= req_data_byte;
         off_ff  <= req_byte_offset;
         drop_ff <= req_drop_count;
         last_ff <= req_segment_last;
      end
      pend_rd_ff    <= pend_rd_in;
      pend_valid_ff <= pend_valid_in;
      pend_moved_ff <= pend_moved_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_moved_ff  <= rsp_moved_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   rrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (data_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rrb_merge_engine #(
      .RING_BYTES (RING_BYTES),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_merge (
      .clock  (clock),
      .reset  (reset),
      .start  (merge_start),
      .tail   (tail),
      .left   (off_ff[AW-1:0]),
      .cnt    (stored_n),
      .fill   (fill_ff),
      .status (merge_stat),
      .moved  (merge_moved)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_out_valid   = rsp_ok_ff;
   assign rsp_moved_count = rsp_moved_ff;
   assign rsp_fill_level  = rsp_fill_ff;

   `RRB_ASSERT_NEXT(a_accept_to_exec, req_valid && !req_stall, state_ff == ST_EXEC,
      "accepted transaction did not enter execute")
   `RRB_ASSERT_NOW(a_merge_done_in_merge, merge_stat.done, state_ff == ST_MERGE,
      "merge finished outside merge state")
   `RRB_ASSERT_NEXT(a_rsp_only_from_finish, !rsp_valid_ff && (state_ff != ST_FINISH),
      !rsp_valid_ff, "result raised outside finish")
   `RRB_ASSERT_NOW(a_seg_counts, 1'b1,
      (segsto_ff <= segidx_ff) && (fill_ff <= CW'(RING_BYTES)),
      "segment or fill counters out of range")

endmodule
